>>> hdl/tseq_pkg.sv
package tseq_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [31:0] STAMP_UNSPEC = 32'hFFFF_FFFF;
    localparam logic [15:0] OPEN_MAX     = 16'hFFFF;

    localparam logic [2:0] MODE_ADD       = 3'd0;
    localparam logic [2:0] MODE_EVICT     = 3'd1;
    localparam logic [2:0] MODE_OPEN_INC  = 3'd2;
    localparam logic [2:0] MODE_OPEN_DEC  = 3'd3;
    localparam logic [2:0] MODE_CLEAR     = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  cpu;
        logic [15:0] log_id;
        logic [31:0] stamp;
    } req_item_t;

    typedef struct packed {
        logic        evicted;
        logic [7:0]  out_cpu;
        logic [15:0] out_id;
        logic [31:0] out_stamp;
        logic        overflow;
        logic [6:0]  entry_count;
        logic [15:0] open_count;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0]  cpu;
        logic [15:0] log_id;
        logic [31:0] stamp;
    } entry_t;

endpackage

>>> hdl/timestamp_sorted_eviction_queue.sv
// Sequence: an add that is appended or dropped, a refused evict and open increment,
//   decrement, clear and no-op go straight to the result; a sorted-in add walks the store
//   first, and evict reads the head entry first; a result waits for rsp_ready if needed.
// Throughput: one item at a time; the sorted insert walks down from the tail, one entry
//   per cycle through the store's ports.
// Reset: entry count, open count, head pointer and retention limit clear to zero;
//   the store itself is not cleared, stale entries lie outside the held range.
module timestamp_sorted_eviction_queue #(
    parameter int DEPTH = tseq_pkg::DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  tseq_pkg::req_item_t   req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output tseq_pkg::rsp_item_t   rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);
    import tseq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_INS   = 3'd2;
    localparam logic [2:0] ST_EVICT = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [15:0]   open_reg, open_next;
    logic [15:0]   retain_limit_reg;
    logic [AW-1:0] j_reg, j_next;
    req_item_t     item_reg, item_next;
    rsp_item_t     res_reg, res_next;
    rsp_item_t     rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    entry_t        mem_wdata;
    logic [AW-1:0] mem_raddr;
    entry_t        mem_rdata;

    logic [16:0]   load;
    logic          evict_ok;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    tseq_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign load     = 17'(count_reg) + 17'(open_reg);
    assign evict_ok = (retain_limit_reg != 16'd0) && (count_reg != '0)
                      && (load > 17'(retain_limit_reg));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        open_next      = open_reg;
        j_next         = j_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_wdata      = '{cpu: item_reg.cpu, log_id: item_reg.log_id, stamp: item_reg.stamp};
        mem_raddr      = head_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req;
                    res_next   = '0;
                    state_next = ST_DONE;
                    case (req.mode)
                        MODE_ADD:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                res_next.overflow = 1'b1;
                            end
                            else if (req.stamp == STAMP_UNSPEC || count_reg == '0)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = phys(head_reg, AW'(count_reg));
                                mem_wdata  = '{cpu: req.cpu, log_id: req.log_id,
                                               stamp: req.stamp};
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                j_next     = AW'(count_reg - CW'(1));
                                mem_raddr  = phys(head_reg, AW'(count_reg - CW'(1)));
                                state_next = ST_WALK;
                            end
                        end
                        MODE_EVICT:
                        begin
                            if (evict_ok)
                            begin
                                mem_raddr  = head_reg;
                                state_next = ST_EVICT;
                            end
                        end
                        MODE_OPEN_INC:
                        begin
                            if (open_reg != OPEN_MAX)
                            begin
                                open_next = open_reg + 16'd1;
                            end
                        end
                        MODE_OPEN_DEC:
                        begin
                            if (open_reg != 16'd0)
                            begin
                                open_next = open_reg - 16'd1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            open_next  = 16'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                mem_we = 1'b1;
                mem_waddr = phys(head_reg, j_reg + AW'(1));
                if (item_reg.stamp <= mem_rdata.stamp)
                begin
                    mem_wdata = mem_rdata;
                    if (j_reg == '0)
                    begin
                        state_next = ST_INS;
                    end
                    else
                    begin
                        j_next    = j_reg - AW'(1);
                        mem_raddr = phys(head_reg, j_reg - AW'(1));
                    end
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_INS:
            begin
                mem_we     = 1'b1;
                mem_waddr  = head_reg;
                count_next = count_reg + CW'(1);
                state_next = ST_DONE;
            end
            ST_EVICT:
            begin
                res_next.evicted   = 1'b1;
                res_next.out_cpu   = mem_rdata.cpu;
                res_next.out_id    = mem_rdata.log_id;
                res_next.out_stamp = mem_rdata.stamp;
                head_next          = phys(head_reg, AW'(1));
                count_next         = count_reg - CW'(1);
                state_next         = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next             = res_reg;
                    rsp_next.entry_count = 7'(count_reg);
                    rsp_next.open_count  = open_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            head_reg         <= '0;
            open_reg         <= 16'd0;
            retain_limit_reg <= 16'd0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            open_reg      <= open_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                retain_limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        item_reg <= item_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_walk_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK || state_reg == ST_INS) |-> mem_we)
        else $error("walk cycle without store write");

    a_evict_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("evict did not pop one entry");

    a_full_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.mode == MODE_ADD && count_reg == DEPTH_C)
        |=> (state_reg == ST_DONE && res_reg.overflow && count_reg == DEPTH_C))
        else $error("add to full store not flagged");

endmodule

>>> hdl/tseq_store.sv
module tseq_store #(
    parameter int DEPTH = tseq_pkg::DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  tseq_pkg::entry_t      wr_data,
    input  logic [AW-1:0]         rd_addr,
    output tseq_pkg::entry_t      rd_data
);
    import tseq_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
